>>> rtl/core/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude unit.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned PIX_W      = CH_W * NUM_CH;
    localparam int unsigned GRAD_W     = 11;
    localparam int unsigned SQ_W       = 22;
    localparam int unsigned ROOT_W     = 9;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned ROW_W      = 17;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned FW_CFG_W   = 11;
    localparam int unsigned FH_CFG_W   = 16;

    localparam logic [SQ_W-1:0]     SAT_LIMIT   = SQ_W'(65280);
    localparam logic [CH_W-1:0]     EDGE_MAX    = 8'd255;
    localparam logic [STEP_W-1:0]   TOP_STEP    = STEP_W'(ROOT_W - 1);
    localparam logic [FW_CFG_W-1:0] FW_RESET    = 11'd1024;
    localparam logic [FH_CFG_W-1:0] FH_RESET    = 16'd768;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SQUARE,
        ST_SQRT,
        ST_ROUND
    } sem_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic square;
        logic sqrt_step;
        logic out_load;
    } sem_cmd_t;

    typedef struct packed {
        logic skip;
        logic valid;
        logic sqrt_last;
    } sem_status_t;

endpackage

>>> rtl/core/sobel_edge_magnitude_rgb_unit.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_unit
// Sobel 3x3 gradient magnitude per RGB channel on a raster pixel stream.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item that yields a result passes through
// acceptance, window update, squares, nine root steps of the per-channel root
// unit and rounding into the output register, where it waits while an earlier
// result is still pending; a flush inside the frame or an item without a result
// returns to idle from the execute step. The next item is accepted while a
// result waits on m_tready. Results lag their pixel by one row plus one pixel;
// after the frame, frame_width+1 flush items drain the rest, and the result of
// the last pixel carries m_tlast. The line stores hold no reset.
module sobel_edge_magnitude_rgb_unit
    import sem_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic             s_tuser,   // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,   // edge_red, edge_green, edge_blue
    output logic             m_tlast,   // frame_last
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    sem_cmd_t    cmd;
    sem_status_t status;
    sem_state_t  state;

    sem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status  (status),
        .cmd     (cmd),
        .state   (state)
    );

    sem_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && state == ST_EXEC))
        else $error("item accepted while another is in work");

    a_result_from_round: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (state == ST_ROUND && (!m_tvalid || m_tready)))
        else $error("result loaded outside rounding step or over pending result");

    a_root_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_SQUARE) |=> (state == ST_SQRT && !status.sqrt_last))
        else $error("root unit not started at full step count");
`endif

endmodule

>>> rtl/core/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/sem_ctrl.sv
// ----------------------------------------------------------------------------
// sem_ctrl
// Item sequencer: accept, window update, squares, root steps, result.
// ----------------------------------------------------------------------------
module sem_ctrl
    import sem_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  sem_status_t status,
    output sem_cmd_t    cmd,
    output sem_state_t  state
);

    sem_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.skip || !status.valid) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: state_next = ST_SQRT;
            ST_SQRT: begin
                if (status.sqrt_last) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EXEC:   cmd.exec = !status.skip;
            ST_SQUARE: cmd.square = 1'b1;
            ST_SQRT:   cmd.sqrt_step = 1'b1;
            ST_ROUND:  cmd.out_load = out_free;
            default:   cmd = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign state    = state_reg;

endmodule

>>> rtl/core/sem_dp.sv
// ----------------------------------------------------------------------------
// sem_dp
// Datapath: line stores, 3x3 window, gradients, squares, root lanes.
// ----------------------------------------------------------------------------
module sem_dp
    import sem_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sem_cmd_t         cmd,
    output sem_status_t      status,
    input  logic [PIX_W-1:0] s_tdata,
    input  logic             s_tuser,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output logic [PIX_W-1:0] m_tdata,
    output logic             m_tlast
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned WX = (WW > FW_CFG_W) ? WW : FW_CFG_W;

    logic [FW_CFG_W-1:0] width_cfg_reg;
    logic [FH_CFG_W-1:0] height_cfg_reg;
    logic [WX-1:0]       w_ext, w_eff;
    logic [FH_CFG_W-1:0] h_eff;
    logic [ROW_W-1:0]    h0, h1, h2;

    logic [CW-1:0]       col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                cmd_reg;
    logic [PIX_W-1:0]    pix_in_reg;
    logic                col_wrap;
    logic [CW-1:0]       rd_addr;

    logic [PIX_W-1:0]    prev_rd, prev2_rd;
    logic [PIX_W-1:0]    pix, top, mid;
    logic                in_frame, mid_ok, top_ok, c_nz, valid, last, frame_end;
    logic [ROW_W-1:0]    crow;
    logic [WX-1:0]       ccol, col_inc;

    logic [PIX_W-1:0]    win_reg  [3][3];
    logic [PIX_W-1:0]    win_m    [3][3];
    logic [PIX_W-1:0]    win_next [3][3];
    logic [PIX_W-1:0]    new_col  [3];

    logic signed [GRAD_W-1:0] gx      [NUM_CH];
    logic signed [GRAD_W-1:0] gy      [NUM_CH];
    logic signed [GRAD_W-1:0] gx_reg  [NUM_CH];
    logic signed [GRAD_W-1:0] gy_reg  [NUM_CH];
    logic [15:0]              s_reg   [NUM_CH];
    logic                     sat_reg [NUM_CH];
    logic [ROOT_W-1:0]        f_reg   [NUM_CH];
    logic [STEP_W-1:0]        k_reg;
    logic [CH_W-1:0]          edge_reg [NUM_CH];
    logic                     last_reg, last_out_reg;

    // Effective frame size
    assign w_ext = WX'(width_cfg_reg);
    assign w_eff = (w_ext == '0) ? WX'(1) :
                   (w_ext > WX'(MAX_WIDTH)) ? WX'(MAX_WIDTH) : w_ext;
    assign h_eff = (height_cfg_reg == '0) ? FH_CFG_W'(1) : height_cfg_reg;
    assign h0    = {1'b0, h_eff};
    assign h1    = h0 + ROW_W'(1);
    assign h2    = h0 + ROW_W'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= FW_RESET;
            height_cfg_reg <= FH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_data[FW_CFG_W-1:0];
                REG_FRAME_HEIGHT: height_cfg_reg <= cfg_data[FH_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign col_wrap = WX'(col_reg) >= w_eff;
    assign rd_addr  = col_wrap ? '0 : col_reg;

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
        .aclk (aclk),
        .we   (cmd.exec),
        .waddr(col_reg),
        .wdata(pix),
        .re   (cmd.load),
        .raddr(rd_addr),
        .rdata(prev_rd)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev2 (
        .aclk (aclk),
        .we   (cmd.exec),
        .waddr(col_reg),
        .wdata(prev_rd),
        .re   (cmd.load),
        .raddr(rd_addr),
        .rdata(prev2_rd)
    );

    // Position and window decisions for the current item
    assign in_frame  = row_reg < h0;
    assign pix       = in_frame ? pix_in_reg : '0;
    assign mid_ok    = (row_reg >= ROW_W'(1)) && (row_reg < h1);
    assign top_ok    = (row_reg >= ROW_W'(2)) && (row_reg < h2);
    assign top       = top_ok ? prev2_rd : '0;
    assign mid       = mid_ok ? prev_rd : '0;
    assign c_nz      = col_reg != '0;
    assign valid     = c_nz ? mid_ok : top_ok;
    assign crow      = c_nz ? row_reg - ROW_W'(1) : row_reg - ROW_W'(2);
    assign ccol      = c_nz ? WX'(col_reg) - WX'(1) : w_eff - WX'(1);
    assign last      = (crow == h0 - ROW_W'(1)) && (ccol == w_eff - WX'(1));
    assign frame_end = row_reg >= h1;
    assign col_inc   = WX'(col_reg) + WX'(1);

    assign status.skip      = (cmd_reg == CMD_FLUSH) && in_frame;
    assign status.valid     = valid;
    assign status.sqrt_last = k_reg == '0;

    assign new_col[0] = top;
    assign new_col[1] = mid;
    assign new_col[2] = pix;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_m[i][0] = win_reg[i][1];
            win_m[i][1] = win_reg[i][2];
            win_m[i][2] = c_nz ? new_col[i] : '0;
            if (frame_end) begin
                win_next[i][0] = '0;
                win_next[i][1] = '0;
                win_next[i][2] = '0;
            end else if (c_nz) begin
                win_next[i][0] = win_m[i][0];
                win_next[i][1] = win_m[i][1];
                win_next[i][2] = win_m[i][2];
            end else begin
                win_next[i][0] = win_reg[i][2];
                win_next[i][1] = '0;
                win_next[i][2] = new_col[i];
            end
        end
    end

    always_comb begin
        logic [CH_W+1:0] xp, xn, yp, yn;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            xp = {2'b0, win_m[0][2][ch*CH_W +: CH_W]} + {2'b0, win_m[2][2][ch*CH_W +: CH_W]}
               + {1'b0, win_m[1][2][ch*CH_W +: CH_W], 1'b0};
            xn = {2'b0, win_m[0][0][ch*CH_W +: CH_W]} + {2'b0, win_m[2][0][ch*CH_W +: CH_W]}
               + {1'b0, win_m[1][0][ch*CH_W +: CH_W], 1'b0};
            yp = {2'b0, win_m[2][0][ch*CH_W +: CH_W]} + {2'b0, win_m[2][2][ch*CH_W +: CH_W]}
               + {1'b0, win_m[2][1][ch*CH_W +: CH_W], 1'b0};
            yn = {2'b0, win_m[0][0][ch*CH_W +: CH_W]} + {2'b0, win_m[0][2][ch*CH_W +: CH_W]}
               + {1'b0, win_m[0][1][ch*CH_W +: CH_W], 1'b0};
            gx[ch] = $signed({1'b0, xp}) - $signed({1'b0, xn});
            gy[ch] = $signed({1'b0, yp}) - $signed({1'b0, yn});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (cmd.load) begin
            col_reg <= rd_addr;
            row_reg <= col_wrap ? row_reg + ROW_W'(1) : row_reg;
        end else if (cmd.exec) begin
            win_reg <= win_next;
            if (frame_end) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (col_inc >= w_eff) begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // Gradients, squares, root lanes and output register
    always_ff @(posedge aclk) begin
        logic [2*GRAD_W-1:0] px, py;
        logic [SQ_W-1:0]     sum;
        logic [ROOT_W-1:0]   t;
        logic [2*ROOT_W-1:0] tt, ff;
        logic                rnd;
        logic [ROOT_W:0]     fr;
        if (cmd.load) begin
            cmd_reg    <= s_tuser;
            pix_in_reg <= s_tdata;
        end
        if (cmd.exec) begin
            gx_reg   <= gx;
            gy_reg   <= gy;
            last_reg <= last;
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            px  = $unsigned((2*GRAD_W)'(gx_reg[ch]) * (2*GRAD_W)'(gx_reg[ch]));
            py  = $unsigned((2*GRAD_W)'(gy_reg[ch]) * (2*GRAD_W)'(gy_reg[ch]));
            sum = px + py;
            t   = f_reg[ch] | (ROOT_W'(1) << k_reg);
            tt  = t * t;
            ff  = f_reg[ch] * f_reg[ch];
            rnd = {2'b0, s_reg[ch]} > (ff + (2*ROOT_W)'(f_reg[ch]));
            fr  = {1'b0, f_reg[ch]} + (ROOT_W+1)'(rnd);
            if (cmd.square) begin
                s_reg[ch]   <= sum[15:0];
                sat_reg[ch] <= sum > SAT_LIMIT;
                f_reg[ch]   <= '0;
            end else if (cmd.sqrt_step) begin
                if (tt <= {2'b0, s_reg[ch]}) begin
                    f_reg[ch] <= t;
                end
            end
            if (cmd.out_load) begin
                edge_reg[ch] <= (sat_reg[ch] || fr > (ROOT_W+1)'(EDGE_MAX)) ?
                                EDGE_MAX : fr[CH_W-1:0];
            end
        end
        if (cmd.square) begin
            k_reg <= TOP_STEP;
        end else if (cmd.sqrt_step) begin
            k_reg <= k_reg - STEP_W'(1);
        end
        if (cmd.out_load) begin
            last_out_reg <= last_reg;
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            m_tdata[ch*CH_W +: CH_W] = edge_reg[ch];
        end
    end
    assign m_tlast = last_out_reg;

endmodule
